>>> sv/ica_pkg.sv
// Shared types, codes and helper functions for the instruction class
// decoder with ADD execution. No dependencies.
`default_nettype none

package ica_pkg;

    // Item action codes
    localparam logic ACT_EXECUTE = 1'b0;
    localparam logic ACT_PRELOAD = 1'b1;

    // Instruction class codes
    localparam logic [3:0] CLS_DATA_PROC  = 4'd0;
    localparam logic [3:0] CLS_MULTIPLY   = 4'd1;
    localparam logic [3:0] CLS_MUL_LONG   = 4'd2;
    localparam logic [3:0] CLS_SWAP       = 4'd3;
    localparam logic [3:0] CLS_BX         = 4'd4;
    localparam logic [3:0] CLS_HALF_REG   = 4'd5;
    localparam logic [3:0] CLS_HALF_IMM   = 4'd6;
    localparam logic [3:0] CLS_UNDEFINED  = 4'd7;
    localparam logic [3:0] CLS_SINGLE_XFR = 4'd8;
    localparam logic [3:0] CLS_BLOCK_XFR  = 4'd9;
    localparam logic [3:0] CLS_BRANCH     = 4'd10;
    localparam logic [3:0] CLS_CP_XFR     = 4'd11;
    localparam logic [3:0] CLS_CP_DATA    = 4'd12;
    localparam logic [3:0] CLS_CP_REG     = 4'd13;
    localparam logic [3:0] CLS_SWI        = 4'd14;

    // Data-processing opcode for ADD
    localparam logic [3:0] OPC_ADD = 4'd4;

    // Immediate shift types
    localparam logic [1:0] SHT_LSL = 2'd0;
    localparam logic [1:0] SHT_LSR = 2'd1;
    localparam logic [1:0] SHT_ASR = 2'd2;
    localparam logic [1:0] SHT_ROR = 2'd3;

    // Program counter register number
    localparam logic [3:0] PC_INDEX = 4'd15;
    localparam logic [31:0] PC_STEP = 32'd4;

    // Result of executing one instruction word
    typedef struct packed {
        logic [3:0]  cls;
        logic        written;
        logic [3:0]  dest;
        logic [31:0] sum;
        logic [3:0]  flags;
    } exec_res_t;

    // Rotate right by a 5-bit amount
    function automatic logic [31:0] ror32(input logic [31:0] v, input logic [4:0] n);
        logic [5:0] back;
        back = 6'd32 - {1'b0, n};
        if (n == 5'd0)
            return v;
        return (v >> n) | (v << back);
    endfunction

endpackage

`default_nettype wire

>>> sv/ica_if.sv
// Valid/ready channel interfaces for the instruction class decoder:
// the item channel and the result channel. No dependencies.
`default_nettype none

interface ica_item_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [31:0] instruction_word;
    logic [3:0]  load_index;
    logic [31:0] load_value;

    modport source (output valid, action, instruction_word, load_index, load_value,
                    input ready);
    modport sink   (input valid, action, instruction_word, load_index, load_value,
                    output ready);
endinterface

interface ica_result_if;
    logic        valid;
    logic        ready;
    logic [3:0]  instr_class;
    logic        reg_written;
    logic [3:0]  dest_index;
    logic [31:0] sum_value;
    logic [3:0]  nzcv_flags;
    logic [31:0] program_counter;

    modport source (output valid, instr_class, reg_written, dest_index, sum_value,
                    nzcv_flags, program_counter, input ready);
    modport sink   (input valid, instr_class, reg_written, dest_index, sum_value,
                    nzcv_flags, program_counter, output ready);
endinterface

`default_nettype wire

>>> sv/ica_execute.sv
// Combinational classify, operand2 shifter and ADD/ADDS unit.
// Depends on ica_pkg.
`default_nettype none

module ica_execute (
    input  wire logic [31:0]          word,
    input  wire logic [31:0]          rn_val,
    input  wire logic [31:0]          rm_val,
    input  wire logic [3:0]           flags,
    output ica_pkg::exec_res_t        res
);

    logic [3:0]  cls;
    logic        is_add;
    logic [4:0]  amt;
    logic [31:0] imm_op;
    logic [31:0] reg_op;
    logic [31:0] op2;
    logic [32:0] sum_full;
    logic [31:0] sum;
    logic        ovf;
    logic [3:0]  add_flags;

    // Sort the word by pattern, undefined ahead of single transfer
    always_comb
    begin
        if ((word & 32'h0FC000F0) == 32'h00000090)      cls = ica_pkg::CLS_MULTIPLY;
        else if ((word & 32'h0F8000F0) == 32'h00800090) cls = ica_pkg::CLS_MUL_LONG;
        else if ((word & 32'h0FB00FF0) == 32'h01000090) cls = ica_pkg::CLS_SWAP;
        else if ((word & 32'h0FFFFFF0) == 32'h012FFF10) cls = ica_pkg::CLS_BX;
        else if ((word & 32'h0E400F90) == 32'h00000090) cls = ica_pkg::CLS_HALF_REG;
        else if ((word & 32'h0E400090) == 32'h00400090) cls = ica_pkg::CLS_HALF_IMM;
        else if ((word & 32'h0E000010) == 32'h06000010) cls = ica_pkg::CLS_UNDEFINED;
        else if ((word & 32'h0C000000) == 32'h04000000) cls = ica_pkg::CLS_SINGLE_XFR;
        else if ((word & 32'h0E000000) == 32'h08000000) cls = ica_pkg::CLS_BLOCK_XFR;
        else if ((word & 32'h0E000000) == 32'h0A000000) cls = ica_pkg::CLS_BRANCH;
        else if ((word & 32'h0E000000) == 32'h0C000000) cls = ica_pkg::CLS_CP_XFR;
        else if ((word & 32'h0F000010) == 32'h0E000000) cls = ica_pkg::CLS_CP_DATA;
        else if ((word & 32'h0F000010) == 32'h0E000010) cls = ica_pkg::CLS_CP_REG;
        else if ((word & 32'h0F000000) == 32'h0F000000) cls = ica_pkg::CLS_SWI;
        else                                            cls = ica_pkg::CLS_DATA_PROC;
    end

    // ADD with immediate or immediate-shifted register operand
    assign is_add = (cls == ica_pkg::CLS_DATA_PROC) && (word[24:21] == ica_pkg::OPC_ADD)
                    && (word[25] || !word[4]);

    // Rotated 8-bit immediate
    assign imm_op = ica_pkg::ror32({24'd0, word[7:0]}, {word[11:8], 1'b0});

    // Register operand shifted by an immediate amount
    assign amt = word[11:7];
    always_comb
    begin
        unique case (word[6:5])
            ica_pkg::SHT_LSL: reg_op = rm_val << amt;
            ica_pkg::SHT_LSR: reg_op = (amt == 5'd0) ? 32'd0 : (rm_val >> amt);
            ica_pkg::SHT_ASR: reg_op = (amt == 5'd0) ? {32{rm_val[31]}}
                                                     : 32'($signed(rm_val) >>> amt);
            ica_pkg::SHT_ROR: reg_op = (amt == 5'd0) ? {flags[1], rm_val[31:1]}
                                                     : ica_pkg::ror32(rm_val, amt);
            default:          reg_op = rm_val;
        endcase
    end

    assign op2 = word[25] ? imm_op : reg_op;

    // Add and derive NZCV
    assign sum_full  = {1'b0, rn_val} + {1'b0, op2};
    assign sum       = sum_full[31:0];
    assign ovf       = (~(rn_val[31] ^ op2[31])) & (rn_val[31] ^ sum[31]);
    assign add_flags = {sum[31], (sum == 32'd0), sum_full[32], ovf};

    // Pack the result; no write gives zero destination and sum
    always_comb
    begin
        res.cls     = cls;
        res.written = is_add;
        res.dest    = is_add ? word[15:12] : 4'd0;
        res.sum     = is_add ? sum : 32'd0;
        res.flags   = (is_add && word[20]) ? add_flags : flags;
    end

endmodule

`default_nettype wire

>>> sv/instruction_classify_add_execute.sv
// Top level of the instruction class decoder with ADD execution.
// Depends on ica_pkg, ica_if (ica_item_if, ica_result_if) and ica_execute.
//
//   channel   direction   carries
//   item      in          action, instruction_word, load_index, load_value
//   result    out         instr_class, reg_written, dest_index, sum_value,
//                         nzcv_flags, program_counter
//
// One item per cycle sustained while results are taken without stalls.
// Stage one registers the item and reads Rn and Rm from the register file memory;
// stage two classifies, shifts, adds, writes back and loads the result register.
// A write made in stage two is forwarded into a read taken in the same cycle.
// Reset clears the flags, R15 and the per-register valid bits (unwritten reads as zero).
// A stalled result holds stage two; stage one still takes an item while it is empty.
`default_nettype none

module instruction_classify_add_execute (
    input  wire logic      clk,
    input  wire logic      rst_n,
    ica_item_if.sink       item,
    ica_result_if.source   result
);

    // Stage one
    logic        s1_valid_reg;
    logic        s1_action_reg;
    logic [31:0] s1_word_reg;
    logic [3:0]  s1_load_index_reg;
    logic [31:0] s1_load_value_reg;
    logic [31:0] rd_a_reg;
    logic [31:0] rd_b_reg;
    logic        vld_a_reg;
    logic        vld_b_reg;
    logic        byp_a_reg;
    logic        byp_b_reg;
    logic [31:0] byp_data_reg;

    // Architectural state
    logic [31:0] rf_mem [16];
    logic [15:0] rf_valid_reg;
    logic [31:0] pc_reg;
    logic [31:0] pc_next;
    logic [3:0]  flags_reg;
    logic [3:0]  flags_next;

    // Result register
    logic        out_valid_reg;
    logic [3:0]  out_class_reg;
    logic        out_written_reg;
    logic [3:0]  out_dest_reg;
    logic [31:0] out_sum_reg;

    logic              accept;
    logic              exec_fire;
    logic [3:0]        rn_idx;
    logic [3:0]        rm_idx;
    logic [31:0]       pc_plus4;
    logic [31:0]       rf_a;
    logic [31:0]       rf_b;
    logic [31:0]       rn_val;
    logic [31:0]       rm_val;
    ica_pkg::exec_res_t res;
    logic              wr_en;
    logic [3:0]        wr_addr;
    logic [31:0]       wr_data;

    // Handshakes
    assign exec_fire  = s1_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !s1_valid_reg || exec_fire;
    assign accept     = item.valid && item.ready;

    // Resolve operands: forwarded write, stored value, reset zero, or R15
    assign rn_idx   = s1_word_reg[19:16];
    assign rm_idx   = s1_word_reg[3:0];
    assign pc_plus4 = pc_reg + ica_pkg::PC_STEP;
    assign rf_a     = byp_a_reg ? byp_data_reg : (vld_a_reg ? rd_a_reg : 32'd0);
    assign rf_b     = byp_b_reg ? byp_data_reg : (vld_b_reg ? rd_b_reg : 32'd0);
    assign rn_val   = (rn_idx == ica_pkg::PC_INDEX) ? pc_plus4 : rf_a;
    assign rm_val   = (rm_idx == ica_pkg::PC_INDEX) ? pc_plus4 : rf_b;

    ica_execute u_execute (
        .word   (s1_word_reg),
        .rn_val (rn_val),
        .rm_val (rm_val),
        .flags  (flags_reg),
        .res    (res)
    );

    // Write-back: R15 lives in pc_reg, the rest in the memory
    always_comb
    begin
        wr_en      = 1'b0;
        wr_addr    = s1_load_index_reg;
        wr_data    = s1_load_value_reg;
        pc_next    = pc_reg;
        flags_next = flags_reg;
        if (exec_fire)
        begin
            if (s1_action_reg == ica_pkg::ACT_PRELOAD)
            begin
                if (s1_load_index_reg == ica_pkg::PC_INDEX)
                    pc_next = s1_load_value_reg;
                else
                    wr_en = 1'b1;
            end
            else
            begin
                pc_next    = pc_plus4;
                flags_next = res.flags;
                wr_addr    = res.dest;
                wr_data    = res.sum;
                if (res.written)
                begin
                    if (res.dest == ica_pkg::PC_INDEX)
                        pc_next = res.sum;
                    else
                        wr_en = 1'b1;
                end
            end
        end
    end

    // Register file memory: write port and two registered read ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
            rf_mem[wr_addr] <= wr_data;
        if (accept)
        begin
            rd_a_reg <= rf_mem[item.instruction_word[19:16]];
            rd_b_reg <= rf_mem[item.instruction_word[3:0]];
        end
    end

    // Stage one payload and forwarding of the concurrent write
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_action_reg     <= item.action;
            s1_word_reg       <= item.instruction_word;
            s1_load_index_reg <= item.load_index;
            s1_load_value_reg <= item.load_value;
            vld_a_reg         <= rf_valid_reg[item.instruction_word[19:16]];
            vld_b_reg         <= rf_valid_reg[item.instruction_word[3:0]];
            byp_a_reg         <= wr_en && (wr_addr == item.instruction_word[19:16]);
            byp_b_reg         <= wr_en && (wr_addr == item.instruction_word[3:0]);
            byp_data_reg      <= wr_data;
        end
    end

    // Control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            rf_valid_reg  <= 16'd0;
            pc_reg        <= 32'd0;
            flags_reg     <= 4'd0;
        end
        else
        begin
            if (item.ready)
                s1_valid_reg <= item.valid;
            if (exec_fire)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
            if (wr_en)
                rf_valid_reg[wr_addr] <= 1'b1;
            pc_reg    <= pc_next;
            flags_reg <= flags_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (exec_fire)
        begin
            if (s1_action_reg == ica_pkg::ACT_PRELOAD)
            begin
                out_class_reg   <= ica_pkg::CLS_DATA_PROC;
                out_written_reg <= 1'b0;
                out_dest_reg    <= 4'd0;
                out_sum_reg     <= 32'd0;
            end
            else
            begin
                out_class_reg   <= res.cls;
                out_written_reg <= res.written;
                out_dest_reg    <= res.dest;
                out_sum_reg     <= res.sum;
            end
        end
    end

    // Flags and R15 in the result are the state after the item
    assign result.valid           = out_valid_reg;
    assign result.instr_class     = out_class_reg;
    assign result.reg_written     = out_written_reg;
    assign result.dest_index      = out_dest_reg;
    assign result.sum_value       = out_sum_reg;
    assign result.nzcv_flags      = flags_reg;
    assign result.program_counter = pc_reg;

`ifndef NO_ASSERTIONS
    a_hold_stage_one: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !exec_fire |=> s1_valid_reg)
        else $error("stage one item dropped while stalled");

    a_preload_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        exec_fire && (s1_action_reg == ica_pkg::ACT_PRELOAD)
        |=> result.valid && !result.reg_written)
        else $error("preload reported a register write");

    a_written_is_data_proc: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.reg_written |-> result.instr_class == ica_pkg::CLS_DATA_PROC)
        else $error("register write from a non data-processing class");

    a_pc_advance: assert property (@(posedge clk) disable iff (!rst_n)
        exec_fire && (s1_action_reg == ica_pkg::ACT_EXECUTE) && !res.written
        |=> pc_reg == $past(pc_reg) + ica_pkg::PC_STEP)
        else $error("R15 did not advance by one word");

    a_flags_stable_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !exec_fire |=> $stable(flags_reg) && $stable(pc_reg))
        else $error("state changed with no item executed");
`endif

endmodule

`default_nettype wire
